>>> rtl/bounded_fifo_with_mean_defines.svh
// assertion macros shared by the rtl files
`ifndef BOUNDED_FIFO_WITH_MEAN_DEFINES_SVH
`define BOUNDED_FIFO_WITH_MEAN_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define BFWM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, disabled in reset
`define BFWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BFWM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define BFWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> rtl/bfwm_pkg.sv
// shared widths, codes and constants for the bounded fifo with mean
package bfwm_pkg;

  localparam int DEPTH  = 16;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 5;
  localparam int ID_W   = 12;
  localparam int HT_W   = 8;
  localparam int SUM_W  = 12;
  localparam int REM_W  = SUM_W - HT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd5;

  // word index of the capacity register
  localparam logic CFG_IDX_CAPACITY = 1'b0;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_REFUSED = 2'd2
  } kind_t;

endpackage

>>> rtl/bounded_fifo_with_mean.sv
// top level: circular record queue with running height sum and mean
// A queue of up to 16 records (id, height); capacity is set over the APB port
// (reset 5, values above 16 act as 16). An insert into a full queue drops the
// oldest record first, then reports the truncated mean of all held heights. A
// remove pops the oldest record and returns its id; a remove on an empty queue
// is refused. start is taken when busy is low; each result is shown for exactly
// one cycle with done high and cannot be held off, so the receiver must take it
// then. A remove goes through S_POP to its result; an insert goes through S_POP,
// S_WRITE and S_DIV, where the divider for the mean resolves one quotient bit per
// cycle over eight steps. busy is low again in the cycle that carries done.
`include "bounded_fifo_with_mean_defines.svh"

module bounded_fifo_with_mean
  import bfwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              action,
  input  logic [ID_W-1:0]   player_id,
  input  logic [HT_W-1:0]   height,
  output logic              done,
  output logic [1:0]        result_kind,
  output logic [ID_W-1:0]   removed_id,
  output logic [HT_W-1:0]   mean_height,
  output logic [CNT_W-1:0]  occupancy,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_WRITE,
    S_DIV
  } state_t;

  state_t            state;
  logic [CAP_W-1:0]  capacity;
  logic [SLOT_W-1:0] head_slot;
  logic [CNT_W-1:0]  entry_count;
  logic [SUM_W-1:0]  height_sum;
  action_t           act_q;
  logic [ID_W-1:0]   pid_q;
  logic [HT_W-1:0]   ht_q;
  logic              div_start;
  logic              div_done;
  logic [HT_W-1:0]   div_quo;

  logic [ID_W-1:0]   id_mem [DEPTH];
  logic [HT_W-1:0]   ht_mem [DEPTH];
  logic [ID_W-1:0]   rd_id;
  logic [HT_W-1:0]   rd_ht;

  logic [CAP_W-1:0]  cap_eff;
  logic              full_drop;
  logic [SLOT_W-1:0] tail_slot;
  logic              accept;
  logic              cfg_wr;

  assign accept    = start && !busy;
  assign busy      = state != S_IDLE;
  assign cap_eff   = (capacity > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : capacity;
  assign full_drop = (CAP_W'(entry_count) >= cap_eff) && (entry_count != '0);
  assign tail_slot = head_slot + entry_count[SLOT_W-1:0];

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == CFG_IDX_CAPACITY) ? {{(32-CAP_W){1'b0}}, capacity} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr && paddr[2] == CFG_IDX_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // record store, oldest entry read every cycle
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      id_mem[tail_slot] <= pid_q;
      ht_mem[tail_slot] <= ht_q;
    end
    rd_id <= id_mem[head_slot];
    rd_ht <= ht_mem[head_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_slot   <= '0;
      entry_count <= '0;
      height_sum  <= '0;
      done        <= 1'b0;
      div_start   <= 1'b0;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            act_q <= action_t'(action);
            pid_q <= player_id;
            ht_q  <= height;
            state <= S_POP;
          end
        end
        S_POP: begin
          if (act_q == ACT_REMOVE) begin
            done        <= 1'b1;
            mean_height <= '0;
            state       <= S_IDLE;
            if (entry_count == '0) begin
              result_kind <= KIND_REFUSED;
              removed_id  <= '0;
              occupancy   <= '0;
            end else begin
              head_slot   <= head_slot + SLOT_W'(1);
              entry_count <= entry_count - CNT_W'(1);
              height_sum  <= height_sum - SUM_W'(rd_ht);
              result_kind <= KIND_REMOVE;
              removed_id  <= rd_id;
              occupancy   <= entry_count - CNT_W'(1);
            end
          end else begin
            // full queue: drop the oldest before appending
            if (full_drop) begin
              head_slot   <= head_slot + SLOT_W'(1);
              entry_count <= entry_count - CNT_W'(1);
              height_sum  <= height_sum - SUM_W'(rd_ht);
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          entry_count <= entry_count + CNT_W'(1);
          height_sum  <= height_sum + SUM_W'(ht_q);
          div_start   <= 1'b1;
          state       <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            done        <= 1'b1;
            result_kind <= KIND_INSERT;
            removed_id  <= '0;
            mean_height <= div_quo;
            occupancy   <= entry_count;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bfwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (height_sum),
    .divisor  (entry_count),
    .done     (div_done),
    .quotient (div_quo)
  );

  `BFWM_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, entry_count <= CNT_W'(DEPTH), "occupancy overflow")
  `BFWM_ASSERT_IMPL(a_empty_sum, clk, rst, entry_count == '0, height_sum == '0, "sum left on empty queue")
  `BFWM_ASSERT_IMPL(a_insert_occ, clk, rst, done, result_kind != KIND_INSERT || occupancy != '0, "insert beat with zero occupancy")
  `BFWM_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy, "accepted command did not raise busy")

endmodule

>>> rtl/bfwm_div.sv
// iterative restoring divider, one quotient bit per cycle
`include "bounded_fifo_with_mean_defines.svh"

module bfwm_div
  import bfwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [HT_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(HT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HT_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [REM_W-1:0]  rem;
  logic [HT_W-1:0]   quo;
  logic [CNT_W-1:0]  dvs;

  logic [CNT_W-1:0]  trial;
  logic              fits;
  logic [CNT_W-1:0]  diff;
  logic [REM_W-1:0]  rem_next;
  logic [HT_W-1:0]   quo_next;

  assign trial    = {rem, quo[HT_W-1]};
  assign fits     = trial >= dvs;
  assign diff     = trial - dvs;
  assign rem_next = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
  assign quo_next = {quo[HT_W-2:0], fits};

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // upper bits start as the partial remainder, quotient fits in HT_W bits
        busy <= 1'b1;
        step <= '0;
        rem  <= dividend[SUM_W-1:HT_W];
        quo  <= dividend[HT_W-1:0];
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= rem_next;
        quo  <= quo_next;
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `BFWM_ASSERT_IMPL(a_div_nonzero, clk, rst, start, divisor != '0, "divide by zero")
  `BFWM_ASSERT_IMPL(a_div_no_restart, clk, rst, start, !busy, "divider restarted while busy")
  `BFWM_ASSERT_IMPL(a_div_rem_range, clk, rst, busy, {1'b0, rem} < dvs, "remainder out of range")
  `BFWM_ASSERT_IMPL(a_div_done_src, clk, rst, done, $past(busy), "done without a running divide")

endmodule

>>> test/tb_top.sv
// testbench for bounded_fifo_with_mean: directed and random queue traffic checked against a predictor
`timescale 1ns / 100ps

module tb_top;
  import bfwm_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int TAIL_CYCLES = 30;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] CAPACITY_ADDR = {CFG_IDX_CAPACITY, 2'b00};

  typedef struct {
    kind_t            kind;
    logic [ID_W-1:0]  rid;
    logic [HT_W-1:0]  mean;
    logic [CNT_W-1:0] occ;
  } queue_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              action = ACT_INSERT;
  logic [ID_W-1:0]   player_id = '0;
  logic [HT_W-1:0]   height = '0;
  logic              done;
  logic [1:0]        result_kind;
  logic [ID_W-1:0]   removed_id;
  logic [HT_W-1:0]   mean_height;
  logic [CNT_W-1:0]  occupancy;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  bounded_fifo_with_mean DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .player_id(player_id), .height(height),
    .done(done), .result_kind(result_kind), .removed_id(removed_id),
    .mean_height(mean_height), .occupancy(occupancy),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // shadow copy of the queue
  logic [ID_W-1:0]  shadow_ids [DEPTH];
  logic [HT_W-1:0]  shadow_hts [DEPTH];
  logic [SLOT_W-1:0] shadow_head;
  logic [CNT_W-1:0] shadow_count;
  logic [SUM_W-1:0] shadow_sum;
  logic [CAP_W-1:0] shadow_cap;

  queue_result_t pending_results[$];
  int  errors = 0;
  int  n_insert = 0, n_remove = 0, n_refused = 0, n_dropped = 0, n_cap_writes = 0;
  int  cycle_cnt = 0;
  bit  no_idle = 1'b0;

  function automatic logic [ID_W-1:0] pop_shadow();
    logic [ID_W-1:0] id;
    id = shadow_ids[shadow_head];
    shadow_sum = shadow_sum - SUM_W'(shadow_hts[shadow_head]);
    shadow_head = shadow_head + SLOT_W'(1);
    shadow_count = shadow_count - CNT_W'(1);
    return id;
  endfunction

  function automatic queue_result_t predict_queue_op(action_t act, logic [ID_W-1:0] pid,
                                                     logic [HT_W-1:0] h);
    queue_result_t r;
    int eff_cap;
    logic [SLOT_W-1:0] tail;
    r.kind = KIND_INSERT;
    r.rid = '0;
    r.mean = '0;
    if (act == ACT_INSERT) begin
      eff_cap = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
      if (int'(shadow_count) >= eff_cap && shadow_count > 0) begin
        void'(pop_shadow());
        n_dropped++;
      end
      tail = shadow_head + SLOT_W'(shadow_count);
      shadow_ids[tail] = pid;
      shadow_hts[tail] = h;
      shadow_count = shadow_count + CNT_W'(1);
      shadow_sum = shadow_sum + SUM_W'(h);
      r.mean = HT_W'(shadow_sum / shadow_count);
      n_insert++;
    end else if (shadow_count == 0) begin
      r.kind = KIND_REFUSED;
      n_refused++;
    end else begin
      r.rid = pop_shadow();
      r.kind = KIND_REMOVE;
      n_remove++;
    end
    r.occ = shadow_count;
    return r;
  endfunction

  // one beat on the command port; start stays high for a back-to-back follower
  task automatic send_item(action_t act, logic [ID_W-1:0] pid, logic [HT_W-1:0] h);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      player_id = ID_W'($urandom);
      height = HT_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    action = act;
    player_id = pid;
    height = h;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_queue_op(act, pid, h));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_drained();
    // every item yields a result, so nothing is in flight once the results are drained
    repeat (2) @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CAPACITY_ADDR;
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    shadow_cap = value;
    n_cap_writes++;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing pending, expected none actual kind %0d",
                 $time, result_kind);
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", int'(want.kind), int'(result_kind));
        check_field("removed_id", int'(want.rid), int'(removed_id));
        check_field("mean_height", int'(want.mean), int'(mean_height));
        check_field("occupancy", int'(want.occ), int'(occupancy));
      end
    end
  end

  task automatic test_basic_ops();
    // defaults after reset: capacity 5
    send_item(ACT_REMOVE, 12'hFFF, 8'hFF);
    send_item(ACT_INSERT, 12'h000, 8'd255);
    send_item(ACT_INSERT, 12'hFFF, 8'd0);
    send_item(ACT_INSERT, 12'hA5A, 8'd128);
    send_item(ACT_INSERT, 12'h5A5, 8'd255);
    send_item(ACT_INSERT, 12'h001, 8'd255);
    send_item(ACT_INSERT, 12'h002, 8'd7);
    repeat (5) send_item(ACT_REMOVE, 12'h000, 8'h00);
    send_item(ACT_REMOVE, 12'h000, 8'h00);
  endtask

  task automatic test_zero_capacity();
    write_capacity(5'd0);
    send_item(ACT_INSERT, 12'h123, 8'd200);
    send_item(ACT_INSERT, 12'h456, 8'd255);
    send_item(ACT_REMOVE, 12'h000, 8'h00);
    send_item(ACT_REMOVE, 12'h000, 8'h00);
  endtask

  task automatic test_capacity_shrink();
    write_capacity(5'd16);
    send_item(ACT_INSERT, 12'h010, 8'd10);
    send_item(ACT_INSERT, 12'h020, 8'd20);
    send_item(ACT_INSERT, 12'h030, 8'd30);
    // capacity below occupancy: only one entry is dropped per insert
    write_capacity(5'd2);
    send_item(ACT_INSERT, 12'h040, 8'd40);
    send_item(ACT_REMOVE, 12'h000, 8'h00);
  endtask

  task automatic random_phase(logic [CAP_W-1:0] cap, int insert_pct, int n_items, bit tall);
    int i;
    int r;
    logic [HT_W-1:0] h;
    write_capacity(cap);
    for (i = 0; i < n_items; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      // now and then let the block run dry before the next beat
      if ($urandom_range(0, 49) == 0) wait_drained();
      r = $urandom_range(0, 7);
      if (tall && r < 6) h = 8'd255;
      else if (r == 0) h = 8'd0;
      else if (r == 1) h = 8'd255;
      else h = HT_W'($urandom);
      if ($urandom_range(1, 100) <= insert_pct)
        send_item(ACT_INSERT, ID_W'($urandom), h);
      else
        send_item(ACT_REMOVE, ID_W'($urandom), h);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix();
    int k;
    random_phase(5'd1, 60, 150, 1'b0);
    random_phase(5'd16, 70, 250, 1'b0);
    random_phase(5'd31, 75, 200, 1'b1);
    random_phase(5'd3, 55, 150, 1'b0);
    random_phase(5'd0, 50, 120, 1'b0);
    random_phase(5'd17, 75, 200, 1'b0);
    random_phase(5'd8, 50, 150, 1'b0);
    random_phase(5'd16, 40, 150, 1'b0);
    for (k = 0; k < 3; k++)
      random_phase(CAP_W'($urandom_range(0, 31)), $urandom_range(35, 75), 60, 1'b0);
  endtask

  initial begin
    shadow_head = '0;
    shadow_count = '0;
    shadow_sum = '0;
    shadow_cap = CAP_RESET;
    for (int s = 0; s < DEPTH; s++) begin
      shadow_ids[s] = '0;
      shadow_hts[s] = '0;
    end
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_ops();
    test_zero_capacity();
    test_capacity_shrink();
    test_random_mix();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d inserts (%0d with drop), %0d removes, %0d refused removes",
             n_insert, n_dropped, n_remove, n_refused);
    $display("over %0d capacity writes including zero, one, sixteen and above depth",
             n_cap_writes);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
             pending_results.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
